FILE: rtl/spo_pkg.sv
package spo_pkg;

   localparam int AXIS_W     = 16;
   localparam int NVEC_W     = AXIS_W + 1;   // axis component after negation
   localparam int SIZE_W     = 22;
   localparam int DOT_W      = 32;           // |axis . axis|, Q.28
   localparam int EXT_TERM_W = SIZE_W + DOT_W;
   localparam int EXT_SUM_W  = EXT_TERM_W + 2;
   localparam int NUM_AXES   = 4;
   localparam int SPLIT_W    = 24;           // low part of a split square

   typedef enum logic [1:0] {
      CMD_BOX_BOX       = 2'd0,
      CMD_CIRCLE_CIRCLE = 2'd1,
      CMD_CIRCLE_BOX    = 2'd2,
      CMD_RESERVED      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // |p*nx + q*ny| for Q1.14 vectors
   function automatic logic [DOT_W-1:0] dot_mag(input logic signed [NVEC_W-1:0] p,
                                                input logic signed [NVEC_W-1:0] q,
                                                input logic signed [NVEC_W-1:0] nx,
                                                input logic signed [NVEC_W-1:0] ny);
      logic signed [2*NVEC_W:0] t;
      t = p * nx + q * ny;
      if (t < 0) begin
         dot_mag = DOT_W'(-t);
      end else begin
         dot_mag = DOT_W'(t);
      end
   endfunction

endpackage

FILE: rtl/spo_front.sv
module spo_front #(
   parameter int COORD_BITS = 24
) (
   input  logic                                clock,
   input  spo_pkg::stage_en_type               en,
   input  logic [1:0]                          req_cmd,
   input  logic signed [COORD_BITS-1:0]        req_a_x,
   input  logic signed [COORD_BITS-1:0]        req_a_y,
   input  logic [spo_pkg::SIZE_W-1:0]          req_a_w,
   input  logic [spo_pkg::SIZE_W-1:0]          req_a_h,
   input  logic [31:0]                         req_a_axis,
   input  logic signed [COORD_BITS-1:0]        req_b_x,
   input  logic signed [COORD_BITS-1:0]        req_b_y,
   input  logic [spo_pkg::SIZE_W-1:0]          req_b_w,
   input  logic [spo_pkg::SIZE_W-1:0]          req_b_h,
   input  logic [31:0]                         req_b_axis,
   output logic [1:0]                          cmd_o,
   output logic [COORD_BITS+16:0]              proj_o [spo_pkg::NUM_AXES],
   output logic [spo_pkg::EXT_TERM_W-1:0]      term_o [spo_pkg::NUM_AXES][4],
   output logic [2*COORD_BITS+1:0]             mx2_o,
   output logic [2*COORD_BITS+1:0]             my2_o,
   output logic [2*spo_pkg::SIZE_W+1:0]        rs2_o,
   output logic signed [COORD_BITS+17:0]       lx_o,
   output logic signed [COORD_BITS+17:0]       ly_o,
   output logic [spo_pkg::SIZE_W-1:0]          aw_o,
   output logic [spo_pkg::SIZE_W-1:0]          bw_o,
   output logic [spo_pkg::SIZE_W-1:0]          bh_o
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = COORD_BITS + 17;
   localparam int LW = COORD_BITS + 18;
   localparam int NA = spo_pkg::NUM_AXES;
   localparam int NW = spo_pkg::NVEC_W;
   localparam int SW = spo_pkg::SIZE_W;

   // stage 1
   logic signed [NW-1:0] ac, as_, bc, bs, nas, nbs;
   logic signed [NW-1:0] nx_i [NA];
   logic signed [NW-1:0] ny_i [NA];

   assign ac  = {req_a_axis[31], req_a_axis[31:16]};
   assign as_ = {req_a_axis[15], req_a_axis[15:0]};
   assign bc  = {req_b_axis[31], req_b_axis[31:16]};
   assign bs  = {req_b_axis[15], req_b_axis[15:0]};
   assign nas = -as_;
   assign nbs = -bs;

   assign nx_i[0] = ac;  assign ny_i[0] = as_;
   assign nx_i[1] = nas; assign ny_i[1] = ac;
   assign nx_i[2] = bc;  assign ny_i[2] = bs;
   assign nx_i[3] = nbs; assign ny_i[3] = bc;

   logic [1:0]                  cmd1_ff;
   logic signed [DW-1:0]        dx_ff, dy_ff;
   logic signed [NW-1:0]        nx_ff [NA];
   logic signed [NW-1:0]        ny_ff [NA];
   logic [spo_pkg::DOT_W-1:0]   er_a_ff [NA];
   logic [spo_pkg::DOT_W-1:0]   eu_a_ff [NA];
   logic [spo_pkg::DOT_W-1:0]   er_b_ff [NA];
   logic [spo_pkg::DOT_W-1:0]   eu_b_ff [NA];
   logic [SW-1:0]               aw1_ff, ah1_ff, bw1_ff, bh1_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         cmd1_ff <= req_cmd;
         dx_ff   <= DW'(req_b_x) - DW'(req_a_x);
         dy_ff   <= DW'(req_b_y) - DW'(req_a_y);
         aw1_ff  <= req_a_w;
         ah1_ff  <= req_a_h;
         bw1_ff  <= req_b_w;
         bh1_ff  <= req_b_h;
         for (int k = 0; k < NA; k++) begin
            nx_ff[k]   <= nx_i[k];
            ny_ff[k]   <= ny_i[k];
            er_a_ff[k] <= spo_pkg::dot_mag(ac, as_, nx_i[k], ny_i[k]);
            eu_a_ff[k] <= spo_pkg::dot_mag(nas, ac, nx_i[k], ny_i[k]);
            er_b_ff[k] <= spo_pkg::dot_mag(bc, bs, nx_i[k], ny_i[k]);
            eu_b_ff[k] <= spo_pkg::dot_mag(nbs, bc, nx_i[k], ny_i[k]);
         end
      end
   end

   // stage 2
   logic signed [DW+17:0] proj_s [NA];
   logic [PW-1:0]         proj_m [NA];
   logic signed [DW-1:0]  ndx, ndy;
   logic [DW-1:0]         mx, my;
   logic [SW:0]           rs;

   assign ndx = -dx_ff;
   assign ndy = -dy_ff;
   assign mx  = (dx_ff < 0) ? ndx : dx_ff;
   assign my  = (dy_ff < 0) ? ndy : dy_ff;
   assign rs  = {1'b0, aw1_ff} + {1'b0, bw1_ff};

   always_comb begin
      for (int k = 0; k < NA; k++) begin
         proj_s[k] = dx_ff * nx_ff[k] + dy_ff * ny_ff[k];
         proj_m[k] = (proj_s[k] < 0) ? PW'(-proj_s[k]) : PW'(proj_s[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         cmd_o <= cmd1_ff;
         for (int k = 0; k < NA; k++) begin
            proj_o[k]    <= proj_m[k];
            term_o[k][0] <= aw1_ff * er_a_ff[k];
            term_o[k][1] <= ah1_ff * eu_a_ff[k];
            term_o[k][2] <= bw1_ff * er_b_ff[k];
            term_o[k][3] <= bh1_ff * eu_b_ff[k];
         end
         mx2_o <= mx * mx;
         my2_o <= my * my;
         rs2_o <= rs * rs;
         lx_o  <= LW'(ndx * nx_ff[2]) + LW'(ndy * ny_ff[2]);
         ly_o  <= LW'(ndy * nx_ff[2]) - LW'(ndx * ny_ff[2]);
         aw_o  <= aw1_ff;
         bw_o  <= bw1_ff;
         bh_o  <= bh1_ff;
      end
   end

endmodule

FILE: rtl/spo_back.sv
module spo_back #(
   parameter int COORD_BITS = 24
) (
   input  logic                                clock,
   input  spo_pkg::stage_en_type               en,
   input  logic [1:0]                          cmd_i,
   input  logic [COORD_BITS+16:0]              proj_i [spo_pkg::NUM_AXES],
   input  logic [spo_pkg::EXT_TERM_W-1:0]      term_i [spo_pkg::NUM_AXES][4],
   input  logic [2*COORD_BITS+1:0]             mx2_i,
   input  logic [2*COORD_BITS+1:0]             my2_i,
   input  logic [2*spo_pkg::SIZE_W+1:0]        rs2_i,
   input  logic signed [COORD_BITS+17:0]       lx_i,
   input  logic signed [COORD_BITS+17:0]       ly_i,
   input  logic [spo_pkg::SIZE_W-1:0]          aw_i,
   input  logic [spo_pkg::SIZE_W-1:0]          bw_i,
   input  logic [spo_pkg::SIZE_W-1:0]          bh_i,
   output logic                                hit_o
);

   localparam int DW    = COORD_BITS + 1;
   localparam int PW    = COORD_BITS + 17;
   localparam int LW    = COORD_BITS + 18;
   localparam int EW    = COORD_BITS + 17;
   localparam int NA    = spo_pkg::NUM_AXES;
   localparam int SW    = spo_pkg::SIZE_W;
   localparam int XS    = spo_pkg::EXT_SUM_W;
   localparam int LSW   = PW + 15;
   localparam int CMPW  = (LSW > XS) ? LSW : XS;
   localparam int SQW   = (2*DW + 1 > 2*SW + 2) ? 2*DW + 1 : 2*SW + 2;
   localparam int QW    = ((LW > SW + 14) ? LW : SW + 14) + 1;
   localparam int LO    = spo_pkg::SPLIT_W;
   localparam int HW    = EW - LO;
   localparam int R2W   = (2*EW + 1 > 2*SW + 28) ? 2*EW + 1 : 2*SW + 28;

   // stage 3: interval sums, circle-circle compare, clamp distance
   logic [1:0]        cmd3_ff;
   logic [CMPW-1:0]   lhs_ff [NA];
   logic [XS-1:0]     ext_ff [NA];
   logic              cc3_ff;
   logic [EW-1:0]     ex_ff, ey_ff;
   logic [SW-1:0]     aw3_ff;

   logic signed [QW-1:0] lxe, lye, hwe, hhe;
   logic [EW-1:0]        ex_in, ey_in;

   assign lxe = QW'(lx_i);
   assign lye = QW'(ly_i);
   assign hwe = signed'(QW'({bw_i, 13'b0}));
   assign hhe = signed'(QW'({bh_i, 13'b0}));

   always_comb begin
      if (lxe > hwe) begin
         ex_in = EW'(lxe - hwe);
      end else if (lxe < -hwe) begin
         ex_in = EW'(-hwe - lxe);
      end else begin
         ex_in = '0;
      end
      if (lye > hhe) begin
         ey_in = EW'(lye - hhe);
      end else if (lye < -hhe) begin
         ey_in = EW'(-hhe - lye);
      end else begin
         ey_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         cmd3_ff <= cmd_i;
         for (int k = 0; k < NA; k++) begin
            lhs_ff[k] <= CMPW'(proj_i[k]) << 15;
            ext_ff[k] <= XS'(term_i[k][0]) + XS'(term_i[k][1])
                       + XS'(term_i[k][2]) + XS'(term_i[k][3]);
         end
         cc3_ff <= (SQW'(mx2_i) + SQW'(my2_i)) < SQW'(rs2_i);
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         aw3_ff <= aw_i;
      end
   end

   // stage 4: axis compares, split squares
   logic [1:0]         cmd4_ff;
   logic               box4_ff, cc4_ff;
   logic [2*LO-1:0]    exll_ff, eyll_ff;
   logic [EW-1:0]      exhl_ff, eyhl_ff;
   logic [2*HW-1:0]    exhh_ff, eyhh_ff;
   logic [2*SW-1:0]    aw2_ff;
   logic [NA-1:0]      ov;

   always_comb begin
      for (int k = 0; k < NA; k++) begin
         ov[k] = lhs_ff[k] <= CMPW'(ext_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         cmd4_ff <= cmd3_ff;
         box4_ff <= &ov;
         cc4_ff  <= cc3_ff;
         exll_ff <= ex_ff[LO-1:0] * ex_ff[LO-1:0];
         eyll_ff <= ey_ff[LO-1:0] * ey_ff[LO-1:0];
         exhl_ff <= ex_ff[EW-1:LO] * ex_ff[LO-1:0];
         eyhl_ff <= ey_ff[EW-1:LO] * ey_ff[LO-1:0];
         exhh_ff <= ex_ff[EW-1:LO] * ex_ff[EW-1:LO];
         eyhh_ff <= ey_ff[EW-1:LO] * ey_ff[EW-1:LO];
         aw2_ff  <= aw3_ff * aw3_ff;
      end
   end

   // stage 5: circle-box compare and selection by command
   logic [R2W-1:0] dist2, r2;
   logic           hit_in;

   assign dist2 = (R2W'(exhh_ff) << (2*LO)) + (R2W'(exhl_ff) << (LO + 1)) + R2W'(exll_ff)
                + (R2W'(eyhh_ff) << (2*LO)) + (R2W'(eyhl_ff) << (LO + 1)) + R2W'(eyll_ff);
   assign r2    = R2W'(aw2_ff) << 28;

   always_comb begin
      case (spo_pkg::cmd_type'(cmd4_ff))
         spo_pkg::CMD_BOX_BOX:       hit_in = box4_ff;
         spo_pkg::CMD_CIRCLE_CIRCLE: hit_in = cc4_ff;
         spo_pkg::CMD_CIRCLE_BOX:    hit_in = dist2 < r2;
         default:                    hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         hit_o <= hit_in;
      end
   end

endmodule

FILE: rtl/shape_pair_overlap_test_unit.sv
// Shape pair overlap test: box/box, circle/circle, circle/box.
//
// Request channel (req_*): one shape pair plus a command. A request is taken
// at a rising edge with req_valid high and req_stall low.
// Response channel (rsp_*): one hit bit per request, in request order, taken
// at a rising edge with rsp_valid high and rsp_stall low.
//
// Five register stages: axis dot products, projections and products,
// interval sums and clamping, axis compares and split squares, final select.
// One request per cycle is sustained while rsp_stall is low, set by the fully
// pipelined datapath (every multiplier is its own unit and is used once per
// request).
//
// Reset clears all stage valid bits; the datapath needs no reset.
// When rsp_stall is high, the output holds and upstream stages keep filling
// any empty slots; req_stall rises only once every stage ahead is full.
// Nothing is dropped or repeated across a stall.
module shape_pair_overlap_test_unit #(
   parameter int COORD_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic signed [COORD_BITS-1:0]   req_a_x,
   input  logic signed [COORD_BITS-1:0]   req_a_y,
   input  logic [21:0]                    req_a_w,
   input  logic [21:0]                    req_a_h,
   input  logic [31:0]                    req_a_axis,
   input  logic signed [COORD_BITS-1:0]   req_b_x,
   input  logic signed [COORD_BITS-1:0]   req_b_y,
   input  logic [21:0]                    req_b_w,
   input  logic [21:0]                    req_b_h,
   input  logic [31:0]                    req_b_axis,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit
);

   localparam int NA = spo_pkg::NUM_AXES;
   localparam int SW = spo_pkg::SIZE_W;

   // stage valid bits; stage 5 is the response register
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   spo_pkg::stage_en_type en;

   // a stage loads when it is empty or the next one loads
   always_comb begin
      en.s5 = !v5_ff || !rsp_stall;
      en.s4 = !v4_ff || en.s5;
      en.s3 = !v3_ff || en.s4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
      v1_in = en.s1 ? req_valid : v1_ff;
      v2_in = en.s2 ? v1_ff : v2_ff;
      v3_in = en.s3 ? v2_ff : v3_ff;
      v4_in = en.s4 ? v3_ff : v4_ff;
      v5_in = en.s5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign req_stall = !en.s1;
   assign rsp_valid = v5_ff;

   // front to back datapath
   logic [1:0]                      cmd2;
   logic [COORD_BITS+16:0]          proj2 [NA];
   logic [spo_pkg::EXT_TERM_W-1:0]  term2 [NA][4];
   logic [2*COORD_BITS+1:0]         mx2, my2;
   logic [2*SW+1:0]                 rs2;
   logic signed [COORD_BITS+17:0]   lx2, ly2;
   logic [SW-1:0]                   aw2, bw2, bh2;

   spo_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .en         (en),
      .req_cmd    (req_cmd),
      .req_a_x    (req_a_x),
      .req_a_y    (req_a_y),
      .req_a_w    (req_a_w),
      .req_a_h    (req_a_h),
      .req_a_axis (req_a_axis),
      .req_b_x    (req_b_x),
      .req_b_y    (req_b_y),
      .req_b_w    (req_b_w),
      .req_b_h    (req_b_h),
      .req_b_axis (req_b_axis),
      .cmd_o      (cmd2),
      .proj_o     (proj2),
      .term_o     (term2),
      .mx2_o      (mx2),
      .my2_o      (my2),
      .rs2_o      (rs2),
      .lx_o       (lx2),
      .ly_o       (ly2),
      .aw_o       (aw2),
      .bw_o       (bw2),
      .bh_o       (bh2)
   );

   spo_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock  (clock),
      .en     (en),
      .cmd_i  (cmd2),
      .proj_i (proj2),
      .term_i (term2),
      .mx2_i  (mx2),
      .my2_i  (my2),
      .rs2_i  (rs2),
      .lx_i   (lx2),
      .ly_i   (ly2),
      .aw_i   (aw2),
      .bw_i   (bw2),
      .bh_i   (bh2),
      .hit_o  (rsp_hit)
   );

endmodule
